// File: hw/rtl/bsrr_pkg.sv
`default_nettype none
package bsrr_pkg;

  localparam int POS_BITS  = 48;
  localparam int SIZE_BITS = 21;
  localparam int CNT_BITS  = 32;

  localparam logic [SIZE_BITS-1:0] MAX_BLOCK     = 21'd1048576;
  localparam logic [SIZE_BITS-1:0] DEFAULT_BLOCK = 21'd512;
  localparam logic [SIZE_BITS-1:0] DEFAULT_RES   = 21'd4;
  localparam logic [7:0]           DEFAULT_RETRY = 8'd2;

  // Configuration register indexes
  localparam logic [2:0] CFG_BLOCK_SIZE   = 3'd0;
  localparam logic [2:0] CFG_RESOLUTION   = 3'd1;
  localparam logic [2:0] CFG_RETRY_LIMIT  = 3'd2;
  localparam logic [2:0] CFG_LENGTH_LIMIT = 3'd3;
  localparam logic [2:0] CFG_BACKTRACK    = 3'd4;

  // Input modes
  localparam logic [1:0] MODE_START   = 2'd0;
  localparam logic [1:0] MODE_OK      = 2'd1;
  localparam logic [1:0] MODE_FAIL    = 2'd2;
  localparam logic [1:0] MODE_IGNORED = 2'd3;

  // Event codes
  localparam logic [3:0] EV_START      = 4'd0;
  localparam logic [3:0] EV_FULL       = 4'd1;
  localparam logic [3:0] EV_PARTIAL    = 4'd2;
  localparam logic [3:0] EV_SHRINK     = 4'd3;
  localparam logic [3:0] EV_RETRY      = 4'd4;
  localparam logic [3:0] EV_AREA_START = 4'd5;
  localparam logic [3:0] EV_HARD_SKIP  = 4'd6;
  localparam logic [3:0] EV_BACKTRACK  = 4'd7;
  localparam logic [3:0] EV_AREA_END   = 4'd8;

  typedef struct packed {
    logic [1:0]           mode;
    logic [SIZE_BITS-1:0] bytes_read;
  } in_item_t;

  typedef struct packed {
    logic [POS_BITS-1:0]  next_offset;
    logic [SIZE_BITS-1:0] next_size;
    logic                 done_res;
    logic [3:0]           event_res;
    logic [CNT_BITS-1:0]  soft_errors;
    logic [CNT_BITS-1:0]  hard_errors;
    logic [POS_BITS-1:0]  damage_bytes;
    logic                 bad_block_valid;
    logic [POS_BITS-1:0]  bad_block_index;
  } out_item_t;

endpackage
`default_nettype wire

// File: hw/rtl/bad_sector_read_recovery.sv
`default_nettype none
// Read recovery sequencer for damaged media. Each input item reports the
// outcome of the last read (start, success with byte count, failure); each
// output item gives the next read offset and size, an event code and the
// running error statistics. The position is divided, the state updated and
// the new position divided again to realign to a block boundary if needed;
// the block offset and bad block index come from a shared bit-serial
// divider that retires one quotient bit per cycle over the 48-bit position.
// One item is processed at a time; the result sits in an output register
// while the next item is taken; an untaken result holds back the next.
module bad_sector_read_recovery
  import bsrr_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [2:0]          cfg_index,
  input  wire logic [POS_BITS-1:0] cfg_data,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire in_item_t            in_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output out_item_t                out_item
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV1 = 3'd1;
  localparam logic [2:0] S_UPD  = 3'd2;
  localparam logic [2:0] S_DIV2 = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  localparam logic [POS_BITS-1:0] POS_MAX = '1;
  localparam logic [CNT_BITS-1:0] CNT_MAX = '1;
  localparam logic [5:0] DIV_LAST = 6'(POS_BITS - 1);

  // Configuration
  logic [SIZE_BITS-1:0] block_size, resolution;
  logic [7:0]           retry_limit;
  logic [POS_BITS-1:0]  length_limit;
  logic                 backtrack_enable;

  // Run state
  logic [2:0]           state;
  in_item_t             item;
  logic [POS_BITS-1:0]  read_pos, area_good_start, area_error_pos, last_bad, damage_total;
  logic [SIZE_BITS-1:0] remaining;
  logic [7:0]           retries_left;
  logic                 in_backtrack, soft_pending, bad_reported, finished;
  logic [CNT_BITS-1:0]  soft_count, hard_count;

  // Pending result flags
  logic                 r_pass, r_end, r_need;
  logic [3:0]           r_ev;
  logic                 r_bv;
  logic [POS_BITS-1:0]  r_bi;

  // Divider
  logic [POS_BITS-1:0]  div_q;
  logic [SIZE_BITS-1:0] div_r;
  logic [5:0]           div_cnt;
  logic [SIZE_BITS:0]   div_sh;
  logic                 div_ge;

  function automatic logic [POS_BITS-1:0] add_pos(input logic [POS_BITS-1:0] a,
                                                  input logic [POS_BITS-1:0] b);
    logic [POS_BITS:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[POS_BITS] ? POS_MAX : s[POS_BITS-1:0];
  endfunction

  // Effective configuration
  logic [SIZE_BITS-1:0] bs_eff, res_raw, res_eff;
  logic [7:0]           retry_eff;
  always_comb begin
    if (block_size == '0) bs_eff = DEFAULT_BLOCK;
    else if (block_size > MAX_BLOCK) bs_eff = MAX_BLOCK;
    else bs_eff = block_size;
    res_raw   = (resolution == '0) ? DEFAULT_RES : resolution;
    res_eff   = (res_raw > bs_eff) ? bs_eff : res_raw;
    retry_eff = (retry_limit == '0) ? 8'd1 : retry_limit;
  end

  assign div_sh = {div_r, div_q[POS_BITS-1]};
  assign div_ge = div_sh >= {1'b0, bs_eff};

  // Step decision for the held item
  logic [POS_BITS-1:0]  rp_n, ags_n, aep_n, lrb_n, dt_n, bi, dpos, ddiff;
  logic [POS_BITS:0]    dsum;
  logic [SIZE_BITS-1:0] rm_n;
  logic [7:0]           rt_n;
  logic                 bt_n, sp_n, br_n, fin_n;
  logic [CNT_BITS-1:0]  sc_n, hc_n;
  logic [3:0]           ev;
  logic                 end_f, bv, add_br, dmg_end, pass;

  always_comb begin
    rp_n = read_pos; rm_n = remaining; rt_n = retries_left;
    bt_n = in_backtrack; sp_n = soft_pending; ags_n = area_good_start;
    aep_n = area_error_pos; lrb_n = last_bad; br_n = bad_reported;
    sc_n = soft_count; hc_n = hard_count; dt_n = damage_total; fin_n = finished;
    ev = EV_START; end_f = 1'b0; bv = 1'b0; bi = '0; add_br = 1'b0;
    dmg_end = 1'b0; pass = 1'b0;
    if (item.mode == MODE_START) begin
      rp_n = '0; rm_n = '0; rt_n = retry_eff; bt_n = 1'b0; sp_n = 1'b0;
      ags_n = '0; aep_n = '0; lrb_n = '0; br_n = 1'b0;
      sc_n = '0; hc_n = '0; dt_n = '0; fin_n = 1'b0;
    end else if (item.mode == MODE_IGNORED || finished) begin
      pass = 1'b1;
    end else if (item.mode == MODE_OK) begin
      if (item.bytes_read == '0) begin
        ev = EV_PARTIAL;
        end_f = 1'b1;
      end else begin
        if (soft_pending) begin
          sp_n = 1'b0;
          if (soft_count != CNT_MAX) sc_n = soft_count + CNT_BITS'(1);
        end
        if (retries_left == '0) begin
          if (remaining > res_eff && backtrack_enable) begin
            rm_n = remaining >> 1;
            rp_n = (read_pos > POS_BITS'(rm_n)) ? read_pos - POS_BITS'(rm_n) : '0;
            bt_n = 1'b1;
            ev = EV_BACKTRACK;
          end else begin
            rt_n = retry_eff; rm_n = '0; add_br = 1'b1; bt_n = 1'b0;
            aep_n = read_pos;
            ev = EV_AREA_END;
          end
        end else begin
          ev   = (item.bytes_read < remaining) ? EV_PARTIAL : EV_FULL;
          rm_n = (item.bytes_read < remaining) ? remaining - item.bytes_read : '0;
          rp_n = add_pos(read_pos, POS_BITS'(item.bytes_read));
        end
      end
    end else begin
      // Read failed
      if (remaining > res_eff && retries_left != '0) begin
        sp_n = 1'b1; rm_n = remaining >> 1; ev = EV_SHRINK;
      end else if (retries_left > 8'd1) begin
        sp_n = 1'b1; rt_n = retries_left - 8'd1; ev = EV_RETRY;
      end else begin
        ev = EV_HARD_SKIP;
        if (retries_left == 8'd1) begin
          sp_n = 1'b0; rt_n = '0;
          rm_n = bs_eff - div_r;
          ags_n = read_pos;
          ev = EV_AREA_START;
        end
        if (!in_backtrack) begin
          if (hard_count != CNT_MAX) hc_n = hard_count + CNT_BITS'(1);
          if (!bad_reported || div_q > last_bad) begin
            br_n = 1'b1; lrb_n = div_q; bv = 1'b1; bi = div_q;
          end
        end
        rp_n = add_pos(read_pos, POS_BITS'(rm_n));
        if (!in_backtrack) rm_n = '0;
      end
    end

    if (!pass && !end_f && length_limit != '0 && rp_n >= length_limit) end_f = 1'b1;
    if (end_f) begin
      fin_n = 1'b1;
      if (rt_n == '0) begin
        dmg_end = 1'b1; rt_n = retry_eff; bt_n = 1'b0; ev = EV_AREA_END;
      end
    end

    // Close a damaged area
    dpos  = dmg_end ? rp_n : read_pos;
    ddiff = (dpos > ags_n) ? dpos - ags_n : '0;
    dsum  = {1'b0, damage_total} + {1'b0, ddiff};
    if (add_br || dmg_end) dt_n = dsum[POS_BITS] ? POS_MAX : dsum[POS_BITS-1:0];
  end

  // Size of the next read
  logic [SIZE_BITS-1:0] rem0, rem1, fin_size;
  logic [POS_BITS-1:0]  len_left;
  always_comb begin
    rem0     = r_need ? bs_eff - div_r : remaining;
    len_left = length_limit - read_pos;
    rem1     = rem0;
    if (length_limit != '0 && add_pos(read_pos, POS_BITS'(rem0)) >= length_limit)
      rem1 = len_left[SIZE_BITS-1:0];
    if (r_pass) fin_size = finished ? '0 : remaining;
    else if (r_end) fin_size = '0;
    else fin_size = rem1;
  end

  assign in_ready = (state == S_IDLE);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      block_size <= DEFAULT_BLOCK; resolution <= DEFAULT_RES;
      retry_limit <= DEFAULT_RETRY; length_limit <= '0; backtrack_enable <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BLOCK_SIZE:   block_size <= cfg_data[SIZE_BITS-1:0];
        CFG_RESOLUTION:   resolution <= cfg_data[SIZE_BITS-1:0];
        CFG_RETRY_LIMIT:  retry_limit <= cfg_data[7:0];
        CFG_LENGTH_LIMIT: length_limit <= cfg_data;
        CFG_BACKTRACK:    backtrack_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; out_valid <= 1'b0;
      read_pos <= '0; remaining <= '0; retries_left <= DEFAULT_RETRY;
      in_backtrack <= 1'b0; soft_pending <= 1'b0; area_good_start <= '0;
      area_error_pos <= '0; last_bad <= '0; bad_reported <= 1'b0;
      soft_count <= '0; hard_count <= '0; damage_total <= '0; finished <= 1'b1;
      r_pass <= 1'b0; r_end <= 1'b0; r_need <= 1'b0;
    end else begin
      // Drop the output item once taken, unless a new one replaces it
      if (out_valid && out_ready && state != S_FIN) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            item <= in_item;
            div_q <= read_pos; div_r <= '0; div_cnt <= DIV_LAST;
            state <= S_DIV1;
          end
        end
        S_DIV1, S_DIV2: begin
          div_r <= div_ge ? SIZE_BITS'(div_sh - {1'b0, bs_eff}) : div_sh[SIZE_BITS-1:0];
          div_q <= {div_q[POS_BITS-2:0], div_ge};
          div_cnt <= div_cnt - 6'd1;
          if (div_cnt == '0) state <= (state == S_DIV1) ? S_UPD : S_FIN;
        end
        S_UPD: begin
          read_pos <= rp_n; remaining <= rm_n; retries_left <= rt_n;
          in_backtrack <= bt_n; soft_pending <= sp_n; area_good_start <= ags_n;
          area_error_pos <= aep_n; last_bad <= lrb_n; bad_reported <= br_n;
          soft_count <= sc_n; hard_count <= hc_n; damage_total <= dt_n;
          finished <= fin_n;
          r_pass <= pass; r_end <= end_f; r_ev <= ev; r_bv <= bv; r_bi <= bi;
          r_need <= !pass && !end_f && rm_n == '0;
          div_q <= rp_n; div_r <= '0; div_cnt <= DIV_LAST;
          state <= (!pass && !end_f && rm_n == '0) ? S_DIV2 : S_FIN;
        end
        S_FIN: begin
          if (!out_valid || out_ready) begin
            if (!r_pass && !r_end) remaining <= rem1;
            out_valid <= 1'b1;
            out_item.next_offset     <= read_pos;
            out_item.next_size       <= fin_size;
            out_item.done_res        <= r_pass ? finished : r_end;
            out_item.event_res       <= r_pass ? EV_START : r_ev;
            out_item.soft_errors     <= soft_count;
            out_item.hard_errors     <= hard_count;
            out_item.damage_bytes    <= damage_total;
            out_item.bad_block_valid <= r_pass ? 1'b0 : r_bv;
            out_item.bad_block_index <= r_pass ? '0 : r_bi;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_done_size: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.done_res |-> out_item.next_size == '0)
    else $error("finished result carries a read size");
  a_live_size: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.done_res |-> out_item.next_size != '0)
    else $error("live result requests an empty read");
  a_bad_event: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.bad_block_valid |->
      (out_item.event_res == EV_AREA_START || out_item.event_res == EV_HARD_SKIP ||
       out_item.event_res == EV_AREA_END))
    else $error("bad block reported without a hard error");
`endif

endmodule
`default_nettype wire

// File: tb/bad_sector_read_recovery_tb.sv
module bad_sector_read_recovery_tb;
  import bsrr_pkg::*;

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [2:0]          cfg_index;
  logic [POS_BITS-1:0] cfg_data;
  logic                in_valid;
  logic                in_ready;
  in_item_t            in_item;
  logic                out_valid;
  logic                out_ready;
  out_item_t           out_item;

  bad_sector_read_recovery u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );

  localparam logic [47:0] POS_MAX = 48'hFFFF_FFFF_FFFF;

  // Register shadow
  logic [20:0] blk_reg, res_reg;
  logic [7:0]  retry_reg;
  logic [47:0] len_reg;
  logic        bt_reg;

  // Sequencer shadow state
  logic [47:0] pos, rem, good_start, err_pos, last_bad, dmg;
  logic [31:0] retries, n_soft, n_hard;
  logic        backtracking, soft_wait, bad_seen, run_over;

  out_item_t   expected_reads[$];
  int          n_errors;
  int          send_idle_pct, recv_stall_pct;

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  function automatic logic [47:0] blk_eff();
    if (blk_reg == 0) return 48'd512;
    if (blk_reg > MAX_BLOCK) return 48'(MAX_BLOCK);
    return 48'(blk_reg);
  endfunction

  function automatic logic [47:0] res_eff();
    logic [47:0] r;
    r = (res_reg == 0) ? 48'd4 : 48'(res_reg);
    if (r > blk_eff()) r = blk_eff();
    return r;
  endfunction

  function automatic logic [31:0] retry_eff();
    return (retry_reg == 0) ? 32'd1 : 32'(retry_reg);
  endfunction

  function automatic logic [47:0] sat_add(logic [47:0] a, logic [47:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[48] ? POS_MAX : s[47:0];
  endfunction

  task automatic close_area();
    logic [47:0] d;
    d = (pos > good_start) ? pos - good_start : 48'd0;
    dmg = sat_add(dmg, d);
  endtask

  function automatic out_item_t make_read(logic [47:0] off, logic [47:0] sz, logic fin,
                                          logic [3:0] ev, logic bv, logic [47:0] bi);
    out_item_t o;
    o.next_offset     = off;
    o.next_size       = sz[20:0];
    o.done_res        = fin;
    o.event_res       = ev;
    o.soft_errors     = n_soft;
    o.hard_errors     = n_hard;
    o.damage_bytes    = dmg;
    o.bad_block_valid = bv;
    o.bad_block_index = bv ? bi : 48'd0;
    return o;
  endfunction

  // Work out the next read request for one outcome
  task automatic predict_next_read(in_item_t it);
    logic [47:0] bs, rs, nbytes, idx, bi;
    logic [3:0]  ev;
    logic        fin, bv;
    bs = blk_eff(); rs = res_eff(); nbytes = 48'(it.bytes_read);
    ev = EV_START; fin = 1'b0; bv = 1'b0; bi = 0;
    if (it.mode == MODE_START) begin
      pos = 0; rem = 0; retries = retry_eff(); backtracking = 0; soft_wait = 0;
      good_start = 0; err_pos = 0; last_bad = 0; bad_seen = 0;
      n_soft = 0; n_hard = 0; dmg = 0; run_over = 0;
    end else if (it.mode == MODE_IGNORED || run_over) begin
      expected_reads.push_back(make_read(pos, run_over ? 48'd0 : rem, run_over, EV_START, 0, 0));
      return;
    end else if (it.mode == MODE_OK) begin
      if (nbytes == 0) begin
        ev = EV_PARTIAL; fin = 1'b1;
      end else begin
        if (soft_wait) begin
          soft_wait = 0;
          if (n_soft != 32'hFFFF_FFFF) n_soft++;
        end
        if (retries == 0) begin
          if (rem > rs && bt_reg) begin
            rem = rem / 2;
            pos = (pos > rem) ? pos - rem : 48'd0;
            backtracking = 1; ev = EV_BACKTRACK;
          end else begin
            retries = retry_eff(); rem = 0; close_area();
            backtracking = 0; err_pos = pos; ev = EV_AREA_END;
          end
        end else begin
          ev = (nbytes < rem) ? EV_PARTIAL : EV_FULL;
          rem = (nbytes < rem) ? rem - nbytes : 48'd0;
          pos = sat_add(pos, nbytes);
        end
      end
    end else begin
      if (rem > rs && retries > 0) begin
        soft_wait = 1; rem = rem / 2; ev = EV_SHRINK;
      end else if (retries > 1) begin
        soft_wait = 1; retries--; ev = EV_RETRY;
      end else begin
        ev = EV_HARD_SKIP;
        if (retries == 1) begin
          soft_wait = 0; retries = 0; rem = bs - pos % bs;
          good_start = pos; ev = EV_AREA_START;
        end
        if (!backtracking) begin
          idx = pos / bs;
          if (n_hard != 32'hFFFF_FFFF) n_hard++;
          if (!bad_seen || idx > last_bad) begin
            bad_seen = 1; last_bad = idx; bv = 1; bi = idx;
          end
        end
        pos = sat_add(pos, rem);
        if (!backtracking) rem = 0;
      end
    end
    if (!fin && len_reg != 0 && pos >= len_reg) fin = 1'b1;
    if (fin) begin
      run_over = 1;
      if (retries == 0) begin
        close_area(); retries = retry_eff(); backtracking = 0; ev = EV_AREA_END;
      end
      expected_reads.push_back(make_read(pos, 0, 1'b1, ev, bv, bi));
      return;
    end
    if (rem == 0) rem = bs - pos % bs;
    if (len_reg != 0 && sat_add(pos, rem) >= len_reg) rem = len_reg - pos;
    expected_reads.push_back(make_read(pos, rem, 1'b0, ev, bv, bi));
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("ERROR %0s: got %0h expected %0h", what, got, want);
    n_errors++;
  endtask

  // Check each accepted read request against the oldest prediction
  always @(posedge clk) begin
    out_item_t w;
    if (!rst && out_valid && out_ready) begin
      if (expected_reads.size() == 0) begin
        report_mismatch("unexpected item", 64'(out_item.next_offset), 0);
      end else begin
        w = expected_reads.pop_front();
        if (out_item.next_offset !== w.next_offset)
          report_mismatch("next_offset", out_item.next_offset, w.next_offset);
        if (out_item.next_size !== w.next_size)
          report_mismatch("next_size", out_item.next_size, w.next_size);
        if (out_item.done_res !== w.done_res)
          report_mismatch("done_res", out_item.done_res, w.done_res);
        if (out_item.event_res !== w.event_res)
          report_mismatch("event_res", out_item.event_res, w.event_res);
        if (out_item.soft_errors !== w.soft_errors)
          report_mismatch("soft_errors", out_item.soft_errors, w.soft_errors);
        if (out_item.hard_errors !== w.hard_errors)
          report_mismatch("hard_errors", out_item.hard_errors, w.hard_errors);
        if (out_item.damage_bytes !== w.damage_bytes)
          report_mismatch("damage_bytes", out_item.damage_bytes, w.damage_bytes);
        if (out_item.bad_block_valid !== w.bad_block_valid)
          report_mismatch("bad_block_valid", out_item.bad_block_valid, w.bad_block_valid);
        if (out_item.bad_block_index !== w.bad_block_index)
          report_mismatch("bad_block_index", out_item.bad_block_index, w.bad_block_index);
      end
    end
  end

  // Stall the receiver at random
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Send one item, idling first at random
  task automatic send_item(logic [1:0] m, logic [20:0] nb);
    in_item_t it;
    it.mode = m; it.bytes_read = nb;
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    in_valid <= 1'b1;
    in_item  <= it;
    predict_next_read(it);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (expected_reads.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [47:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    case (idx)
      CFG_BLOCK_SIZE:   blk_reg = val[20:0];
      CFG_RESOLUTION:   res_reg = val[20:0];
      CFG_RETRY_LIMIT:  retry_reg = val[7:0];
      CFG_LENGTH_LIMIT: len_reg = val;
      CFG_BACKTRACK:    bt_reg = val[0];
      default: ;
    endcase
  endtask

  task automatic set_config(logic [20:0] b, logic [20:0] r, logic [7:0] n,
                            logic [47:0] len, logic bt);
    wait_drained();
    write_reg(CFG_BLOCK_SIZE, 48'(b));
    write_reg(CFG_RESOLUTION, 48'(r));
    write_reg(CFG_RETRY_LIMIT, 48'(n));
    write_reg(CFG_LENGTH_LIMIT, len);
    write_reg(CFG_BACKTRACK, 48'(bt));
    cfg_we <= 1'b0;
  endtask

  // Exercise ignored inputs and every input mode
  task automatic test_directed();
    send_item(MODE_OK, 21'd100);
    send_item(MODE_FAIL, 21'h1FFFFF);
    send_item(MODE_IGNORED, 21'd0);
    send_item(MODE_START, 21'h1FFFFF);
    send_item(MODE_IGNORED, 21'd5);
    send_item(MODE_OK, 21'd100);
    send_item(MODE_OK, 21'd1000);
    send_item(MODE_FAIL, 0);
    send_item(MODE_FAIL, 0);
    send_item(MODE_FAIL, 0);
    send_item(MODE_FAIL, 0);
    send_item(MODE_FAIL, 0);
    send_item(MODE_FAIL, 0);
    send_item(MODE_FAIL, 0);
    send_item(MODE_FAIL, 0);
    send_item(MODE_FAIL, 0);
    send_item(MODE_OK, 21'd64);
    send_item(MODE_FAIL, 0);
    send_item(MODE_OK, 21'd8);
    send_item(MODE_OK, 21'd8);
    send_item(MODE_OK, 21'd0);
    send_item(MODE_OK, 21'd4);
  endtask

  // Run the sequencer with zero (default) and maximum configuration values
  task automatic test_extremes();
    set_config(21'd0, 21'd0, 8'd0, 48'd0, 1'b0);
    send_item(MODE_START, 0);
    send_item(MODE_FAIL, 0);
    send_item(MODE_OK, 21'd1);
    set_config(21'h1FFFFF, 21'h1FFFFF, 8'hFF, POS_MAX, 1'b1);
    send_item(MODE_START, 0);
    repeat (20) send_item(MODE_OK, 21'h1FFFFF);
    send_item(MODE_FAIL, 0);
    send_item(MODE_FAIL, 0);
  endtask

  // Random runs: mostly read outcomes, a few restarts and stray codes
  task automatic test_random(int n_items);
    int k, p;
    logic [20:0] nb;
    send_item(MODE_START, 21'($urandom));
    for (k = 0; k < n_items; k++) begin
      p = $urandom_range(99);
      if (p < 2) nb = 21'($urandom);
      else if (p < 50) nb = 21'($urandom_range(1, 64));
      else nb = 21'($urandom_range(1, 1200));
      p = $urandom_range(99);
      if (p < 2) send_item(MODE_START, nb);
      else if (p < 4) send_item(MODE_IGNORED, nb);
      else if (p < 50) send_item(MODE_FAIL, nb);
      else if (p < 51) send_item(MODE_OK, 21'd0);
      else send_item(MODE_OK, nb);
    end
  endtask

  initial begin
    n_errors = 0;
    rst = 1'b1; cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    in_valid = 1'b0; in_item = '0;
    send_idle_pct = 0; recv_stall_pct = 0;
    blk_reg = DEFAULT_BLOCK; res_reg = DEFAULT_RES; retry_reg = DEFAULT_RETRY;
    len_reg = 0; bt_reg = 1'b1;
    pos = 0; rem = 0; retries = 2; backtracking = 0; soft_wait = 0;
    good_start = 0; err_pos = 0; last_bad = 0; bad_seen = 0;
    n_soft = 0; n_hard = 0; dmg = 0; run_over = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_extremes();
    set_config(21'd64, 21'd2, 8'd3, 48'd0, 1'b1);
    test_random(450);
    send_idle_pct = 57;
    set_config(21'd512, 21'd4, 8'd1, 48'd5000, 1'b1);
    test_random(450);
    send_idle_pct = 0; recv_stall_pct = 57;
    set_config(21'd1000, 21'd1, 8'd2, 48'd0, 1'b0);
    test_random(450);
    send_idle_pct = 12; recv_stall_pct = 12;
    set_config(21'd16, 21'd16, 8'd4, 48'd3000, 1'b1);
    test_random(450);
    wait_drained();

    if (n_errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

// File: bad_sector_read_recovery.f
hw/rtl/bsrr_pkg.sv
hw/rtl/bad_sector_read_recovery.sv
tb/bad_sector_read_recovery_tb.sv
